// File: rtl/ptu_pkg.sv
// Shared types and constants for the PTP time arithmetic pipeline.
`timescale 1ns / 1ps

package ptu_pkg;

   // operation codes carried on req_action
   typedef enum logic [1:0] {
      ACT_ADD   = 2'd0,
      ACT_SUB   = 2'd1,
      ACT_HALVE = 2'd2,
      ACT_NORM  = 2'd3
   } action_type;

   localparam logic [29:0] NS_PER_SEC    = 30'd1000000000;
   localparam logic [29:0] HALF_SEC_NS   = 30'd500000000;
   localparam logic [30:0] NS_PER_SEC_31 = 31'd1000000000;

   // stage 1 -> stage 2: wrapped seconds and exact nanosecond sum
   typedef struct packed {
      logic        valid;
      logic        halve;
      logic [31:0] sec;
      logic [32:0] ns;
   } sum_stage_type;

   // stage 2 -> stage 3: seconds, quotient in -4..4, remainder below one second
   typedef struct packed {
      logic        valid;
      logic        halve;
      logic [31:0] sec;
      logic [3:0]  quot;
      logic [30:0] rem;
   } split_stage_type;

   // final normalized result
   typedef struct packed {
      logic        valid;
      logic [31:0] sec;
      logic [30:0] ns;
   } result_type;

   // mag * 10^9 for mag in 0..4
   function automatic logic signed [33:0] ns_multiple(input logic [2:0] mag);
      logic signed [33:0] step;
      unique case (mag)
         3'd1:    step = 34'sd1000000000;
         3'd2:    step = 34'sd2000000000;
         3'd3:    step = 34'sd3000000000;
         3'd4:    step = 34'sd4000000000;
         default: step = 34'sd0;
      endcase
      return step;
   endfunction

endpackage

// File: rtl/ptu_combine.sv
// Stage 1: forms the seconds and the exact nanosecond sum for each operation.
`timescale 1ns / 1ps

module ptu_combine import ptu_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [1:0]    action,
   input  logic [31:0]   x_seconds,
   input  logic [31:0]   x_nanoseconds,
   input  logic [31:0]   y_seconds,
   input  logic [31:0]   y_nanoseconds,
   output sum_stage_type sum_o
);

   sum_stage_type sum_ff;
   sum_stage_type sum_in;
   logic [32:0]   xn_wide;
   logic [32:0]   yn_wide;

   // seconds wrap at 32 bits, nanoseconds kept exact at 33 bits
   always_comb begin
      xn_wide      = {x_nanoseconds[31], x_nanoseconds};
      yn_wide      = {y_nanoseconds[31], y_nanoseconds};
      sum_in.valid = in_valid;
      sum_in.halve = 1'b0;
      unique case (action_type'(action))
         ACT_ADD: begin
            sum_in.sec = x_seconds + y_seconds;
            sum_in.ns  = xn_wide + yn_wide;
         end
         ACT_SUB: begin
            sum_in.sec = x_seconds - y_seconds;
            sum_in.ns  = xn_wide - yn_wide;
         end
         ACT_HALVE: begin
            sum_in.halve = 1'b1;
            sum_in.sec   = x_seconds;
            sum_in.ns    = xn_wide;
         end
         default: begin
            sum_in.sec = x_seconds;
            sum_in.ns  = xn_wide;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sum_ff.halve <= sum_in.halve;
      sum_ff.sec   <= sum_in.sec;
      sum_ff.ns    <= sum_in.ns;
      if (reset) begin
         sum_ff.valid <= 1'b0;
      end else begin
         sum_ff.valid <= sum_in.valid;
      end
   end

   assign sum_o = sum_ff;

endmodule

// File: rtl/ptu_ns_split.sv
// Stage 2: truncating split of the nanosecond sum into whole seconds and remainder.
`timescale 1ns / 1ps

module ptu_ns_split import ptu_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  sum_stage_type   sum_i,
   output split_stage_type split_o
);

   split_stage_type    split_ff;
   split_stage_type    split_in;
   logic signed [33:0] ns_wide;
   logic signed [33:0] step;
   logic signed [33:0] rem_wide;
   logic [3:0]         pos_hit;
   logic [3:0]         neg_hit;
   logic [3:0]         hit;
   logic [2:0]         mag;
   logic               ns_neg;

   // |ns| <= 2^32, so the quotient is at most 4: compare against each multiple
   always_comb begin
      ns_wide = $signed({sum_i.ns[32], sum_i.ns});
      ns_neg  = sum_i.ns[32];
      for (int k = 1; k <= 4; k++) begin
         pos_hit[k-1] = ns_wide >= ns_multiple(3'(k));
         neg_hit[k-1] = ns_wide <= -ns_multiple(3'(k));
      end
      hit = ns_neg ? neg_hit : pos_hit;
      priority if (hit[3]) mag = 3'd4;
      else if (hit[2])     mag = 3'd3;
      else if (hit[1])     mag = 3'd2;
      else if (hit[0])     mag = 3'd1;
      else                 mag = 3'd0;
      step     = ns_multiple(mag);
      rem_wide = ns_neg ? ns_wide + step : ns_wide - step;

      split_in.valid = sum_i.valid;
      split_in.halve = sum_i.halve;
      split_in.sec   = sum_i.sec;
      split_in.quot  = ns_neg ? 4'(-$signed({1'b0, mag})) : {1'b0, mag};
      split_in.rem   = rem_wide[30:0];
   end

   always_ff @(posedge clock) begin
      split_ff.halve <= split_in.halve;
      split_ff.sec   <= split_in.sec;
      split_ff.quot  <= split_in.quot;
      split_ff.rem   <= split_in.rem;
      if (reset) begin
         split_ff.valid <= 1'b0;
      end else begin
         split_ff.valid <= split_in.valid;
      end
   end

   assign split_o = split_ff;

endmodule

// File: rtl/ptu_settle.sv
// Stages 3 to 6: fold the quotient into seconds, fix the sign, and halve.
`timescale 1ns / 1ps

module ptu_settle import ptu_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  split_stage_type split_i,
   output result_type      result_o
);

   // stage 3: exact seconds plus quotient
   logic        s3_valid_ff, s3_valid_in;
   logic        s3_halve_ff, s3_halve_in;
   logic [32:0] s3_sec_ff, s3_sec_in;
   logic [30:0] s3_rem_ff, s3_rem_in;

   // stage 4: sign fix, or floor form of the total for halving
   logic        s4_valid_ff, s4_valid_in;
   logic        s4_halve_ff, s4_halve_in;
   logic [32:0] s4_sec_ff, s4_sec_in;
   logic [30:0] s4_ns_ff, s4_ns_in;

   // stage 5: floor of the total over two
   logic        s5_valid_ff, s5_valid_in;
   logic        s5_halve_ff, s5_halve_in;
   logic [31:0] s5_sec_ff, s5_sec_in;
   logic [30:0] s5_ns_ff, s5_ns_in;

   // stage 6: back to truncated form
   result_type  result_ff, result_in;

   logic        rem_neg, rem_pos, sec_pos, sec_neg;
   logic [29:0] floor_rem, half_rem;
   logic        round_up;
   logic        full_sec, to_trunc;

   // stage 3
   always_comb begin
      s3_valid_in = split_i.valid;
      s3_halve_in = split_i.halve;
      s3_sec_in   = {split_i.sec[31], split_i.sec} + {{29{split_i.quot[3]}}, split_i.quot};
      s3_rem_in   = split_i.rem;
   end

   // stage 4: one borrow or carry between the parts
   always_comb begin
      rem_neg     = s3_rem_ff[30];
      rem_pos     = !s3_rem_ff[30] && (|s3_rem_ff);
      sec_neg     = s3_sec_ff[31];
      sec_pos     = !s3_sec_ff[31] && (|s3_sec_ff[31:0]);
      s4_valid_in = s3_valid_ff;
      s4_halve_in = s3_halve_ff;
      s4_sec_in   = s3_sec_ff;
      s4_ns_in    = s3_rem_ff;
      priority if (s3_halve_ff) begin
         // remainder made non-negative so the halving works on a floor split
         if (rem_neg) begin
            s4_sec_in = s3_sec_ff - 33'd1;
            s4_ns_in  = s3_rem_ff + NS_PER_SEC_31;
         end
      end else if (sec_pos && rem_neg) begin
         s4_sec_in = s3_sec_ff - 33'd1;
         s4_ns_in  = s3_rem_ff + NS_PER_SEC_31;
      end else if (sec_neg && rem_pos) begin
         s4_sec_in = s3_sec_ff + 33'd1;
         s4_ns_in  = s3_rem_ff - NS_PER_SEC_31;
      end
   end

   // stage 5: an odd second moves half a second into the nanoseconds;
   // negative odd totals round toward zero
   always_comb begin
      floor_rem   = s4_ns_ff[29:0];
      round_up    = s4_sec_ff[32] && floor_rem[0];
      half_rem    = (s4_sec_ff[0] ? HALF_SEC_NS : 30'd0) + {1'b0, floor_rem[29:1]}
                    + {29'd0, round_up};
      s5_valid_in = s4_valid_ff;
      s5_halve_in = s4_halve_ff;
      s5_sec_in   = s4_halve_ff ? s4_sec_ff[32:1] : s4_sec_ff[31:0];
      s5_ns_in    = s4_halve_ff ? {1'b0, half_rem} : s4_ns_ff;
   end

   // stage 6: full second carries out; negative seconds take a negative remainder
   always_comb begin
      full_sec        = s5_halve_ff && (s5_ns_ff == {1'b0, NS_PER_SEC});
      to_trunc        = s5_halve_ff && s5_sec_ff[31] && (|s5_ns_ff) && !full_sec;
      result_in.valid = s5_valid_ff;
      result_in.sec   = (full_sec || to_trunc) ? s5_sec_ff + 32'd1 : s5_sec_ff;
      priority if (full_sec) result_in.ns = 31'd0;
      else if (to_trunc)     result_in.ns = s5_ns_ff - NS_PER_SEC_31;
      else                   result_in.ns = s5_ns_ff;
   end

   always_ff @(posedge clock) begin
      s3_halve_ff   <= s3_halve_in;
      s3_sec_ff     <= s3_sec_in;
      s3_rem_ff     <= s3_rem_in;
      s4_halve_ff   <= s4_halve_in;
      s4_sec_ff     <= s4_sec_in;
      s4_ns_ff      <= s4_ns_in;
      s5_halve_ff   <= s5_halve_in;
      s5_sec_ff     <= s5_sec_in;
      s5_ns_ff      <= s5_ns_in;
      result_ff.sec <= result_in.sec;
      result_ff.ns  <= result_in.ns;
      if (reset) begin
         s3_valid_ff     <= 1'b0;
         s4_valid_ff     <= 1'b0;
         s5_valid_ff     <= 1'b0;
         result_ff.valid <= 1'b0;
      end else begin
         s3_valid_ff     <= s3_valid_in;
         s4_valid_ff     <= s4_valid_in;
         s5_valid_ff     <= s5_valid_in;
         result_ff.valid <= result_in.valid;
      end
   end

   assign result_o = result_ff;

endmodule

// File: rtl/ptp_time_arithmetic_unit.sv
// Top level of the seconds-plus-nanoseconds time arithmetic pipeline.
`timescale 1ns / 1ps

// Adds, subtracts, halves or normalizes PTP times held as 32-bit seconds plus
// signed nanoseconds. Every result comes out normalized: |nanoseconds| below one
// second, and the nanoseconds carry the sign of the seconds whenever the seconds
// are nonzero; seconds wrap at 32 bits. The block takes one item per clock cycle
// and returns each result as a one-cycle strobe on rsp_valid with the result on
// the rsp_ ports; results leave in order. Each item passes through six register
// stages: operand combine, split of the nanoseconds by 10^9, seconds fold, sign
// fix, halving, and final rounding. The receiver cannot hold results off and the
// pipeline never stalls, so busy is high only while reset is asserted.

module ptp_time_arithmetic_unit import ptu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_x_seconds,
   input  logic [31:0] req_x_nanoseconds,
   input  logic [31:0] req_y_seconds,
   input  logic [31:0] req_y_nanoseconds,
   output logic        rsp_valid,
   output logic [31:0] rsp_result_seconds,
   output logic [30:0] rsp_result_nanoseconds
);

   localparam int PIPE_DEPTH = 6;

   sum_stage_type   sum_stage;
   split_stage_type split_stage;
   result_type      result;
   logic            accept;

   assign busy   = reset;
   assign accept = start && !busy;

   ptu_combine u_combine (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (accept),
      .action        (req_action),
      .x_seconds     (req_x_seconds),
      .x_nanoseconds (req_x_nanoseconds),
      .y_seconds     (req_y_seconds),
      .y_nanoseconds (req_y_nanoseconds),
      .sum_o         (sum_stage)
   );

   ptu_ns_split u_ns_split (
      .clock   (clock),
      .reset   (reset),
      .sum_i   (sum_stage),
      .split_o (split_stage)
   );

   ptu_settle u_settle (
      .clock    (clock),
      .reset    (reset),
      .split_i  (split_stage),
      .result_o (result)
   );

   assign rsp_valid              = result.valid;
   assign rsp_result_seconds     = result.sec;
   assign rsp_result_nanoseconds = result.ns;

   // every accepted item comes out exactly once
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $past(accept, PIPE_DEPTH))
      else $error("result strobe does not match accepted items");

   // nanoseconds stay strictly below one second in magnitude
   a_ns_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_result_nanoseconds) < $signed({1'b0, NS_PER_SEC}) &&
                     $signed(rsp_result_nanoseconds) > -$signed({1'b0, NS_PER_SEC})))
      else $error("result nanoseconds out of range");

   // positive seconds never pair with negative nanoseconds
   a_sign_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $signed(rsp_result_seconds) > 0) |-> !rsp_result_nanoseconds[30])
      else $error("sign of nanoseconds disagrees with positive seconds");

   // negative seconds never pair with positive nanoseconds
   a_sign_neg: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_seconds[31]) |->
         (rsp_result_nanoseconds[30] || rsp_result_nanoseconds == 31'd0))
      else $error("sign of nanoseconds disagrees with negative seconds");

endmodule

// File: tb/ptp_time_arithmetic_unit_checker.sv
// Checker for the PTP time arithmetic unit: predicts each result and compares it.
`timescale 1ns / 1ps

module ptp_time_arithmetic_unit_checker import ptu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_x_seconds,
   input  logic [31:0] req_x_nanoseconds,
   input  logic [31:0] req_y_seconds,
   input  logic [31:0] req_y_nanoseconds,
   input  logic        rsp_valid,
   input  logic [31:0] rsp_result_seconds,
   input  logic [30:0] rsp_result_nanoseconds,
   output int          fail_count,
   output int          outstanding
);

   localparam longint NS_PER_SECOND = 64'sd1000000000;
   localparam int     MAX_REPORTS   = 10;

   typedef struct packed {
      logic [31:0] sec;
      logic [30:0] ns;
   } ptp_time_type;

   // expected normalized times, oldest first; counters start at zero
   ptp_time_type expected_times[$];
   int           result_index;

   // fold an exact nanosecond count into wrapping seconds, then fix the sign
   function automatic ptp_time_type fold_time(input logic [31:0] sec, input longint ns);
      longint       quot;
      longint       rem;
      logic [31:0]  s;
      ptp_time_type folded;
      quot = ns / NS_PER_SECOND;
      rem  = ns % NS_PER_SECOND;
      s    = sec + quot[31:0];
      if ($signed(s) > 0 && rem < 0) begin
         s   = s - 32'd1;
         rem = rem + NS_PER_SECOND;
      end else if ($signed(s) < 0 && rem > 0) begin
         s   = s + 32'd1;
         rem = rem - NS_PER_SECOND;
      end
      folded.sec = s;
      folded.ns  = rem[30:0];
      return folded;
   endfunction

   // expected time for one operation
   function automatic ptp_time_type predict_time_op(input action_type act,
                                                    input logic [31:0] xs,
                                                    input logic [31:0] xn_bits,
                                                    input logic [31:0] ys,
                                                    input logic [31:0] yn_bits);
      longint       xn;
      longint       yn;
      longint       total;
      longint       half;
      longint       half_sec;
      ptp_time_type t;
      xn = longint'($signed(xn_bits));
      yn = longint'($signed(yn_bits));
      case (act)
         ACT_ADD: t = fold_time(xs + ys, xn + yn);
         ACT_SUB: t = fold_time(xs - ys, xn - yn);
         ACT_HALVE: begin
            // halve the whole nanosecond count, truncating toward zero
            total    = longint'($signed(xs)) * NS_PER_SECOND + xn;
            half     = total / 2;
            half_sec = half / NS_PER_SECOND;
            t        = fold_time(half_sec[31:0], half % NS_PER_SECOND);
         end
         default: t = fold_time(xs, xn);
      endcase
      return t;
   endfunction

   task automatic log_failure(input string what);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("ERROR @%0t: %s", $realtime, what);
   endtask

   // compare results first, then record the item taken at this edge
   always @(posedge clock) begin
      ptp_time_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_times.size() == 0) begin
               log_failure($sformatf("result %0d (sec %0d ns %0d) with no item pending",
                  result_index, $signed(rsp_result_seconds),
                  $signed(rsp_result_nanoseconds)));
            end else begin
               want = expected_times.pop_front();
               if (want.sec !== rsp_result_seconds || want.ns !== rsp_result_nanoseconds)
                  log_failure($sformatf(
                     "result %0d: expected sec %0d ns %0d, got sec %0d ns %0d",
                     result_index, $signed(want.sec), $signed(want.ns),
                     $signed(rsp_result_seconds), $signed(rsp_result_nanoseconds)));
            end
            result_index++;
         end
         if (start && !busy)
            expected_times.push_back(predict_time_op(action_type'(req_action),
               req_x_seconds, req_x_nanoseconds, req_y_seconds, req_y_nanoseconds));
      end
      outstanding = expected_times.size();
   end

endmodule

// File: tb/ptp_time_arithmetic_unit_tb.sv
// Testbench top for the PTP time arithmetic unit: stimulus, checker hookup, verdict.
`timescale 1ns / 1ps

module ptp_time_arithmetic_unit_tb import ptu_pkg::*;;

   localparam int ITEMS_PER_PHASE = 510;
   localparam int DRAIN_CYCLES    = 12;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_action;
   logic [31:0] req_x_seconds;
   logic [31:0] req_x_nanoseconds;
   logic [31:0] req_y_seconds;
   logic [31:0] req_y_nanoseconds;
   logic        rsp_valid;
   logic [31:0] rsp_result_seconds;
   logic [30:0] rsp_result_nanoseconds;
   int          fail_count;
   int          outstanding;

   ptp_time_arithmetic_unit dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_action             (req_action),
      .req_x_seconds          (req_x_seconds),
      .req_x_nanoseconds      (req_x_nanoseconds),
      .req_y_seconds          (req_y_seconds),
      .req_y_nanoseconds      (req_y_nanoseconds),
      .rsp_valid              (rsp_valid),
      .rsp_result_seconds     (rsp_result_seconds),
      .rsp_result_nanoseconds (rsp_result_nanoseconds)
   );

   ptp_time_arithmetic_unit_checker checker_i (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_action             (req_action),
      .req_x_seconds          (req_x_seconds),
      .req_x_nanoseconds      (req_x_nanoseconds),
      .req_y_seconds          (req_y_seconds),
      .req_y_nanoseconds      (req_y_nanoseconds),
      .rsp_valid              (rsp_valid),
      .rsp_result_seconds     (rsp_result_seconds),
      .rsp_result_nanoseconds (rsp_result_nanoseconds),
      .fail_count             (fail_count),
      .outstanding            (outstanding)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // hard stop in case the pipeline hangs
   initial begin
      #2000000;
      $display("ptp_time_arithmetic_unit_tb NOT OK");
      $finish;
   end

   // seconds: full range, near zero, or near the wrap points
   function automatic logic [31:0] pick_seconds();
      logic [31:0] v;
      case ($urandom_range(0, 3))
         0: v = $urandom();
         1: v = 32'($urandom_range(0, 10)) - 32'd5;
         2: v = $urandom_range(0, 1) ? 32'h7fffffff - 32'($urandom_range(0, 3))
                                     : 32'h80000000 + 32'($urandom_range(0, 3));
         default: v = 32'($urandom_range(0, 200000)) - 32'd100000;
      endcase
      return v;
   endfunction

   // nanoseconds: mostly within one second, some unnormalized or extreme
   function automatic logic [31:0] pick_nanos();
      logic [31:0] v;
      case ($urandom_range(0, 7))
         0, 1: v = $urandom();
         2: begin
            case ($urandom_range(0, 5))
               0: v = 32'd999999999;
               1: v = -32'sd999999999;
               2: v = 32'd1000000000;
               3: v = -32'sd1000000000;
               4: v = 32'd0;
               default: v = $urandom_range(0, 1) ? 32'd1 : 32'hffffffff;
            endcase
         end
         3: v = $urandom_range(0, 1) ? 32'h7fffffff - 32'($urandom_range(0, 3))
                                     : 32'h80000000 + 32'($urandom_range(0, 3));
         default: v = 32'($urandom_range(0, 1999999998)) - 32'd999999999;
      endcase
      return v;
   endfunction

   // present one item at the falling edge and hold it until it is taken
   task automatic issue_time_op(input action_type act, input logic [31:0] xs,
                                input logic [31:0] xn, input logic [31:0] ys,
                                input logic [31:0] yn);
      req_action        = act;
      req_x_seconds     = xs;
      req_x_nanoseconds = xn;
      req_y_seconds     = ys;
      req_y_nanoseconds = yn;
      start             = 1'b1;
      while (busy) @(negedge clock);
      @(posedge clock);
      @(negedge clock);
   endtask

   // random items with the sender idle about idle_pct percent of the time
   task automatic run_random_ops(input int count, input int idle_pct);
      repeat (count) begin
         while ($urandom_range(0, 99) < idle_pct) begin
            start = 1'b0;
            @(negedge clock);
         end
         issue_time_op(action_type'($urandom_range(0, 3)), pick_seconds(), pick_nanos(),
                       pick_seconds(), pick_nanos());
      end
   endtask

   // hold off the sender until every pending result is back
   task automatic wait_for_drain();
      start = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   initial begin
      reset             = 1'b1;
      start             = 1'b0;
      req_action        = ACT_ADD;
      req_x_seconds     = '0;
      req_x_nanoseconds = '0;
      req_y_seconds     = '0;
      req_y_nanoseconds = '0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // directed: field extremes, each operation, wraps, signs and zero seconds
      issue_time_op(ACT_ADD, 32'd0, 32'd0, 32'd0, 32'd0);
      issue_time_op(ACT_ADD, 32'h7fffffff, 32'd999999999, 32'd0, 32'd1);
      issue_time_op(ACT_ADD, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      issue_time_op(ACT_ADD, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
      issue_time_op(ACT_ADD, 32'hffffffff, 32'd999999999, 32'd0, 32'd1);
      issue_time_op(ACT_SUB, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
      issue_time_op(ACT_SUB, 32'd0, 32'h7fffffff, 32'd0, 32'h80000000);
      issue_time_op(ACT_SUB, 32'd5, 32'hffffffff, 32'd0, 32'd0);
      issue_time_op(ACT_SUB, 32'd1, 32'd0, 32'd0, 32'd1000000000);
      issue_time_op(ACT_SUB, 32'h80000000, 32'd0, 32'd1, 32'd0);
      issue_time_op(ACT_HALVE, 32'h7fffffff, 32'h7fffffff, 32'hffffffff, 32'hffffffff);
      issue_time_op(ACT_HALVE, 32'h80000000, 32'h80000000, 32'h12345678, 32'h9abcdef0);
      issue_time_op(ACT_HALVE, 32'd0, 32'hffffffff, 32'h7fffffff, 32'h80000000);
      issue_time_op(ACT_HALVE, 32'd1, 32'd0, 32'd0, 32'd0);
      issue_time_op(ACT_HALVE, 32'hffffffff, 32'd0, 32'd0, 32'd0);
      issue_time_op(ACT_NORM, 32'd0, -32'sd5, 32'hdeadbeef, 32'h55555555);
      issue_time_op(ACT_NORM, 32'd0, 32'd999999999, 32'd0, 32'd0);
      issue_time_op(ACT_NORM, -32'sd3, 32'd500, 32'd0, 32'd0);
      issue_time_op(ACT_NORM, 32'd3, -32'sd500, 32'd0, 32'd0);
      issue_time_op(ACT_NORM, 32'h7fffffff, 32'h7fffffff, 32'hffffffff, 32'hffffffff);
      issue_time_op(ACT_NORM, 32'h80000000, 32'h80000000, 32'd0, 32'd0);
      issue_time_op(ACT_NORM, 32'h80000000, 32'h7fffffff, 32'd0, 32'd0);
      wait_for_drain();

      // random phases: light sender gaps, heavy gaps, then back to back
      run_random_ops(ITEMS_PER_PHASE, 23);
      wait_for_drain();
      run_random_ops(ITEMS_PER_PHASE, 79);
      run_random_ops(ITEMS_PER_PHASE, 0);

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("ptp_time_arithmetic_unit_tb OK");
      else
         $display("ptp_time_arithmetic_unit_tb NOT OK");
      $finish;
   end

endmodule
